[sv/apid_pkg.sv]
`timescale 1ns / 1ps

package apid_pkg;

    // Payload layout
    localparam int FIELD_W   = 32;
    localparam int NUM_AXES  = 6;
    localparam int IN_BITS   = NUM_AXES * FIELD_W + 1;
    localparam int S_TDATA_W = 200;
    localparam int M_TDATA_W = 40;

    // Register widths
    localparam int AXIS_W     = 3;
    localparam int MARGIN_W   = 31;
    localparam int GAIN_W     = 24;
    localparam int STATUS_W   = 2;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    // Register indexes (byte address is 4 * index)
    localparam logic [REG_IDX_W-1:0] REG_AXIS_SELECT = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MARGIN      = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_P      = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_I      = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_D      = 3'd4;

    // Reset values
    localparam logic [AXIS_W-1:0]   AXIS_RESET   = 3'd0;
    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 31'd3277;
    localparam logic [GAIN_W-1:0]   GAIN_P_RESET = 24'd32768;
    localparam logic [GAIN_W-1:0]   GAIN_I_RESET = 24'd0;
    localparam logic [GAIN_W-1:0]   GAIN_D_RESET = 24'd0;

    // Axis codes
    localparam logic [AXIS_W-1:0] AXIS_LIN_X = 3'd0;
    localparam logic [AXIS_W-1:0] AXIS_LIN_Y = 3'd1;
    localparam logic [AXIS_W-1:0] AXIS_LIN_Z = 3'd2;
    localparam logic [AXIS_W-1:0] AXIS_ANG_X = 3'd3;
    localparam logic [AXIS_W-1:0] AXIS_ANG_Y = 3'd4;
    localparam logic [AXIS_W-1:0] AXIS_ANG_Z = 3'd5;

    // Action status codes
    localparam logic [STATUS_W-1:0] STATUS_IDLE    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RUNNING = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SUCCESS = 2'd2;

    typedef struct packed {
        logic [AXIS_W-1:0]          axis_sel;
        logic [MARGIN_W-1:0]        margin;
        logic signed [GAIN_W-1:0]   gain_p;
        logic signed [GAIN_W-1:0]   gain_i;
        logic signed [GAIN_W-1:0]   gain_d;
    } cfg_t;

    typedef struct packed {
        logic [STATUS_W-1:0] action_status;
        logic                in_margin;
        logic                drive_valid;
        logic [FIELD_W-1:0]  drive;
    } result_t;

    typedef logic [NUM_AXES-1:0][FIELD_W-1:0] err_vec_t;

endpackage

[sv/apid_regs.sv]
`timescale 1ns / 1ps

module apid_regs
    import apid_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic [AXIS_W-1:0]    axis_sel_reg;
    logic [MARGIN_W-1:0]  margin_reg;
    logic [GAIN_W-1:0]    gain_p_reg;
    logic [GAIN_W-1:0]    gain_i_reg;
    logic [GAIN_W-1:0]    gain_d_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            axis_sel_reg <= AXIS_RESET;
            margin_reg   <= MARGIN_RESET;
            gain_p_reg   <= GAIN_P_RESET;
            gain_i_reg   <= GAIN_I_RESET;
            gain_d_reg   <= GAIN_D_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_AXIS_SELECT: axis_sel_reg <= pwdata[AXIS_W-1:0];
                REG_MARGIN:      margin_reg   <= pwdata[MARGIN_W-1:0];
                REG_GAIN_P:      gain_p_reg   <= pwdata[GAIN_W-1:0];
                REG_GAIN_I:      gain_i_reg   <= pwdata[GAIN_W-1:0];
                REG_GAIN_D:      gain_d_reg   <= pwdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_AXIS_SELECT: prdata = APB_DATA_W'(axis_sel_reg);
            REG_MARGIN:      prdata = APB_DATA_W'(margin_reg);
            REG_GAIN_P:      prdata = APB_DATA_W'(gain_p_reg);
            REG_GAIN_I:      prdata = APB_DATA_W'(gain_i_reg);
            REG_GAIN_D:      prdata = APB_DATA_W'(gain_d_reg);
            default:         prdata = '0;
        endcase
    end

    assign cfg.axis_sel = axis_sel_reg;
    assign cfg.margin   = margin_reg;
    assign cfg.gain_p   = $signed(gain_p_reg);
    assign cfg.gain_i   = $signed(gain_i_reg);
    assign cfg.gain_d   = $signed(gain_d_reg);

endmodule

[sv/apid_core.sv]
`timescale 1ns / 1ps

module apid_core
    import apid_pkg::*;
#(
    parameter int ERROR_WIDTH    = 32,
    parameter int INTEGRAL_WIDTH = 40
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     step,
    input  cfg_t     cfg,
    input  err_vec_t errs,
    input  logic     enable,
    output result_t  result
);

    localparam int EW     = (ERROR_WIDTH < FIELD_W) ? ERROR_WIDTH : FIELD_W;
    localparam int IW     = INTEGRAL_WIDTH;
    localparam int P_W    = EW + GAIN_W;
    localparam int D_W    = EW + 1 + GAIN_W;
    localparam int I_W    = IW + GAIN_W;
    localparam int SUM_W  = ((I_W > D_W) ? I_W : D_W) + 2;
    localparam int ISUM_W = ((IW > EW) ? IW : EW) + 1;

    logic signed [IW-1:0] integral_reg, integral_next;
    logic signed [EW-1:0] prev_err_reg, prev_err_next;
    logic                 was_en_reg;

    logic signed [EW-1:0]     err_sel;
    logic [EW-1:0]            err_mag;
    logic                     in_margin;
    logic signed [IW-1:0]     integral_use;
    logic signed [EW:0]       err_diff;
    logic signed [P_W-1:0]    p_term;
    logic signed [D_W-1:0]    d_term;
    logic signed [I_W-1:0]    i_term;
    logic signed [SUM_W-1:0]  pid_sum;
    logic signed [SUM_W-1:0]  pid_shift;
    logic [FIELD_W-1:0]       drive_sat;
    logic signed [ISUM_W-1:0] int_sum;
    logic signed [IW-1:0]     int_sat;

    always_comb begin
        case (cfg.axis_sel)
            AXIS_LIN_X: err_sel = $signed(errs[0][EW-1:0]);
            AXIS_LIN_Y: err_sel = $signed(errs[1][EW-1:0]);
            AXIS_LIN_Z: err_sel = $signed(errs[2][EW-1:0]);
            AXIS_ANG_X: err_sel = $signed(errs[3][EW-1:0]);
            AXIS_ANG_Y: err_sel = $signed(errs[4][EW-1:0]);
            AXIS_ANG_Z: err_sel = $signed(errs[5][EW-1:0]);
            default:    err_sel = '0;
        endcase
    end

    // Most negative error negates onto itself, which reads right as unsigned.
    assign err_mag      = err_sel[EW-1] ? EW'(-err_sel) : EW'(err_sel);
    assign in_margin    = FIELD_W'(err_mag) < FIELD_W'(cfg.margin);
    assign integral_use = in_margin ? '0 : integral_reg;

    assign err_diff = err_sel - prev_err_reg;
    assign p_term   = err_sel * cfg.gain_p;
    assign d_term   = err_diff * cfg.gain_d;
    assign i_term   = integral_use * cfg.gain_i;
    assign pid_sum  = SUM_W'(p_term) + SUM_W'(i_term) + SUM_W'(d_term);

    // Arithmetic shift floors toward minus infinity; clamp to 32 bits.
    assign pid_shift = pid_sum >>> 16;

    always_comb begin
        if (&pid_shift[SUM_W-1:FIELD_W-1] || ~|pid_shift[SUM_W-1:FIELD_W-1]) begin
            drive_sat = pid_shift[FIELD_W-1:0];
        end else if (pid_shift[SUM_W-1]) begin
            drive_sat = {1'b1, {(FIELD_W-1){1'b0}}};
        end else begin
            drive_sat = {1'b0, {(FIELD_W-1){1'b1}}};
        end
    end

    assign int_sum = ISUM_W'(integral_use) + ISUM_W'(err_sel);

    always_comb begin
        if (&int_sum[ISUM_W-1:IW-1] || ~|int_sum[ISUM_W-1:IW-1]) begin
            int_sat = int_sum[IW-1:0];
        end else if (int_sum[ISUM_W-1]) begin
            int_sat = {1'b1, {(IW-1){1'b0}}};
        end else begin
            int_sat = {1'b0, {(IW-1){1'b1}}};
        end
    end

    always_comb begin
        result.in_margin = in_margin;
        if (enable) begin
            result.drive         = drive_sat;
            result.drive_valid   = 1'b1;
            result.action_status = STATUS_RUNNING;
        end else if (was_en_reg) begin
            result.drive         = '0;
            result.drive_valid   = 1'b1;
            result.action_status = STATUS_SUCCESS;
        end else begin
            result.drive         = '0;
            result.drive_valid   = 1'b0;
            result.action_status = STATUS_IDLE;
        end
    end

    // In-margin clears the integral even on idle words.
    assign integral_next = enable ? int_sat : integral_use;
    assign prev_err_next = enable ? err_sel : prev_err_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integral_reg <= '0;
            prev_err_reg <= '0;
            was_en_reg   <= 1'b0;
        end else if (step) begin
            integral_reg <= integral_next;
            prev_err_reg <= prev_err_next;
            was_en_reg   <= enable;
        end
    end

endmodule

[sv/axis_pid_with_margin.sv]
`timescale 1ns / 1ps
// Channel   Ports                    Payload
// input     s_tvalid/s_tready/s_tdata six Q16.16 errors, enable flag
// result    m_tvalid/m_tready/m_tdata drive, drive_valid, in_margin, action_status
// config    APB psel..pready         axis_select, margin, gain_p, gain_i, gain_d
//
// One word per cycle sustained while m_tready is high; an accepted word sits in the input
// register, then one pass through the PID multipliers sets the m_tdata result register.
// The integral-times-gain multiplier and the three-term sum set the critical path.
// aresetn is synchronous: clears both stages, the integral, previous error and registers.
// A stalled m_tready holds the result; the input register then fills and s_tready drops.

module axis_pid_with_margin
    import apid_pkg::*;
#(
    parameter int ERROR_WIDTH    = 32,
    parameter int INTEGRAL_WIDTH = 40
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // err_lin_x, err_lin_y, err_lin_z, err_ang_x, err_ang_y, err_ang_z, enable, zero pad
    input  logic [S_TDATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // drive, drive_valid, in_margin, action_status, zero pad
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t    cfg;
    result_t core_result;

    logic               in_valid_reg, in_valid_next;
    logic [IN_BITS-1:0] in_data_reg;
    logic               out_valid_reg, out_valid_next;
    result_t            out_data_reg;
    logic               s_accept;
    logic               advance;
    err_vec_t           errs;
    logic               enable;

    apid_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign advance  = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | advance;
    assign s_accept = s_tvalid & s_tready;

    assign in_valid_next  = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_data_reg <= s_tdata[IN_BITS-1:0];
        end
        if (advance) begin
            out_data_reg <= core_result;
        end
    end

    assign errs   = in_data_reg[NUM_AXES*FIELD_W-1:0];
    assign enable = in_data_reg[IN_BITS-1];

    apid_core #(
        .ERROR_WIDTH    (ERROR_WIDTH),
        .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .cfg     (cfg),
        .errs    (errs),
        .enable  (enable),
        .result  (core_result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_data_reg);

`ifndef ASSERT_OFF
    // An enabled word must come out as a running result on the next cycle.
    a_run_status: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && enable |=> out_valid_reg && out_data_reg.drive_valid
            && out_data_reg.action_status == STATUS_RUNNING)
        else $error("enabled word did not produce a running result");

    // A held input word must not be dropped while the result side is stalled.
    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("input word lost while stalled");

    // Unpublished drive must read as zero with idle status.
    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_data_reg.drive_valid |->
            out_data_reg.drive == '0 && out_data_reg.action_status == STATUS_IDLE)
        else $error("idle result carries a drive or status");
`endif

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import apid_pkg::*;

    localparam int INTEG_W = 40;
    localparam logic signed [127:0] TERM_CAP  = 128'sd1 <<< 60;
    localparam logic signed [127:0] INTEG_MAX = (128'sd1 <<< (INTEG_W - 1)) - 1;
    localparam logic signed [127:0] INTEG_MIN = -(128'sd1 <<< (INTEG_W - 1));
    localparam logic signed [127:0] DRIVE_MAX = 128'sd2147483647;
    localparam logic signed [127:0] DRIVE_MIN = -128'sd2147483648;
    // axis codes past the six error fields select a zero error
    localparam logic [AXIS_W-1:0] AXIS_UNUSED_LO = 3'd6;
    localparam logic [AXIS_W-1:0] AXIS_UNUSED_HI = 3'd7;
    localparam int STALL_LIMIT = 5000;

    class pid_scoreboard;
        logic [AXIS_W-1:0]         axis_sel;
        logic [MARGIN_W-1:0]       margin;
        logic signed [GAIN_W-1:0]  gain_p;
        logic signed [GAIN_W-1:0]  gain_i;
        logic signed [GAIN_W-1:0]  gain_d;
        logic signed [INTEG_W-1:0] integ;
        logic signed [FIELD_W-1:0] prev_err;
        bit                        was_enabled;
        result_t                   drive_q[$];
        int                        errors;

        function new();
            axis_sel    = AXIS_RESET;
            margin      = MARGIN_RESET;
            gain_p      = GAIN_P_RESET;
            gain_i      = GAIN_I_RESET;
            gain_d      = GAIN_D_RESET;
            integ       = '0;
            prev_err    = '0;
            was_enabled = 1'b0;
            errors      = 0;
        endfunction

        function void set_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] val);
            case (idx)
                REG_AXIS_SELECT: axis_sel = val[AXIS_W-1:0];
                REG_MARGIN:      margin   = val[MARGIN_W-1:0];
                REG_GAIN_P:      gain_p   = val[GAIN_W-1:0];
                REG_GAIN_I:      gain_i   = val[GAIN_W-1:0];
                REG_GAIN_D:      gain_d   = val[GAIN_W-1:0];
                default: ;
            endcase
        endfunction

        function logic signed [127:0] clamp_term(logic signed [127:0] x);
            if (x > TERM_CAP)
                return TERM_CAP;
            if (x < -TERM_CAP)
                return -TERM_CAP;
            return x;
        endfunction

        function int pending();
            return drive_q.size();
        endfunction

        // Advance the controller state by one tick and queue the word it must produce.
        function void note_input(logic [S_TDATA_W-1:0] w);
            logic signed [FIELD_W-1:0] e;
            logic signed [127:0]       ev, pv, iv, tot, q, nv;
            longint                    mag;
            bit                        en, in_band;
            result_t                   r;
            en = w[IN_BITS-1];
            if (axis_sel < NUM_AXES)
                e = w[axis_sel * FIELD_W +: FIELD_W];
            else
                e = '0;
            if (e < 0)
                mag = -longint'(e);
            else
                mag = longint'(e);
            in_band = mag < longint'(margin);
            if (in_band)
                integ = '0;
            r = '0;
            r.in_margin = in_band;
            if (en) begin
                ev  = e;
                pv  = prev_err;
                iv  = integ;
                tot = clamp_term(ev * gain_p) + clamp_term(iv * gain_i)
                    + clamp_term((ev - pv) * gain_d);
                q = tot >>> 16;
                if (q > DRIVE_MAX)
                    r.drive = 32'h7FFF_FFFF;
                else if (q < DRIVE_MIN)
                    r.drive = 32'h8000_0000;
                else
                    r.drive = q[FIELD_W-1:0];
                nv = iv + ev;
                if (nv > INTEG_MAX)
                    nv = INTEG_MAX;
                else if (nv < INTEG_MIN)
                    nv = INTEG_MIN;
                integ = nv[INTEG_W-1:0];
                prev_err = e;
                r.drive_valid   = 1'b1;
                r.action_status = STATUS_RUNNING;
            end else if (was_enabled) begin
                r.drive_valid   = 1'b1;
                r.action_status = STATUS_SUCCESS;
            end else begin
                r.action_status = STATUS_IDLE;
            end
            was_enabled = en;
            drive_q.push_back(r);
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] d);
            result_t got, want;
            got = d[$bits(result_t)-1:0];
            if (drive_q.size() == 0) begin
                $display("%0t: unexpected word, expected none actual %h", $time, got);
                errors++;
                return;
            end
            want = drive_q.pop_front();
            if (got.drive !== want.drive) begin
                $display("%0t: drive expected %h actual %h", $time, want.drive, got.drive);
                errors++;
            end
            if (got.drive_valid !== want.drive_valid) begin
                $display("%0t: drive_valid expected %b actual %b",
                         $time, want.drive_valid, got.drive_valid);
                errors++;
            end
            if (got.in_margin !== want.in_margin) begin
                $display("%0t: in_margin expected %b actual %b",
                         $time, want.in_margin, got.in_margin);
                errors++;
            end
            if (got.action_status !== want.action_status) begin
                $display("%0t: action_status expected %0d actual %0d",
                         $time, want.action_status, got.action_status);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    // err_lin_x, err_lin_y, err_lin_z, err_ang_x, err_ang_y, err_ang_z, enable, zero pad
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    // drive, drive_valid, in_margin, action_status, zero pad
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    pid_scoreboard sb;
    bit tx_idle_on;
    bit rx_idle_on;
    bit hold_req;
    int rx_hold;
    bit en_state;
    int en_left;
    int stall_cycles;

    axis_pid_with_margin uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Receiver: random stall bursts, plus one long hold on request.
    initial begin
        rx_hold  = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                rx_hold  = 150;
                hold_req = 1'b0;
            end
            if (rx_hold == 0 && rx_idle_on && $urandom_range(0, 7) == 0)
                rx_hold = $urandom_range(1, 19);
            if (rx_hold > 0) begin
                m_tready <= 1'b0;
                rx_hold--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] val);
        logic [31:0] mask;
        logic [31:0] got;
        int          w;
        case (idx)
            REG_AXIS_SELECT: w = AXIS_W;
            REG_MARGIN:      w = MARGIN_W;
            default:         w = GAIN_W;
        endcase
        mask = (32'd1 << w) - 32'd1;
        @(negedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_reg(idx, val);
        // read back in the next transfer
        @(negedge aclk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        got = prdata;
        if ((got & mask) !== (val & mask)) begin
            $display("%0t: register %0d expected %h actual %h", $time, idx, val & mask, got & mask);
            sb.errors++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic configure(logic [AXIS_W-1:0] axis, logic [MARGIN_W-1:0] m,
                             logic [GAIN_W-1:0] gp, logic [GAIN_W-1:0] gi,
                             logic [GAIN_W-1:0] gd);
        drain();
        write_reg(REG_AXIS_SELECT, 32'(axis));
        write_reg(REG_MARGIN, 32'(m));
        write_reg(REG_GAIN_P, 32'(gp));
        write_reg(REG_GAIN_I, 32'(gi));
        write_reg(REG_GAIN_D, 32'(gd));
    endtask

    // Place e on the selected axis (any axis when none is selected), random elsewhere.
    task automatic send_sel(logic [31:0] e, bit en);
        err_vec_t             errs;
        logic [S_TDATA_W-1:0] w;
        int                   sel;
        int                   gap;
        for (int i = 0; i < NUM_AXES; i++)
            errs[i] = $urandom();
        sel = (sb.axis_sel < NUM_AXES) ? int'(sb.axis_sel) : $urandom_range(0, NUM_AXES - 1);
        errs[sel] = e;
        w = '0;
        w[NUM_AXES*FIELD_W-1:0] = errs;
        w[IN_BITS-1] = en;
        gap = 0;
        if (tx_idle_on && rx_hold == 0 && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 19);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(w);
    endtask

    function automatic logic [31:0] pick_error(logic [MARGIN_W-1:0] m);
        longint      lim;
        logic [31:0] v;
        lim = longint'(m);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom();
            4, 5, 6: begin
                case ($urandom_range(0, 3))
                    0:       v = 32'(lim - 1);
                    1:       v = 32'(lim);
                    2:       v = 32'(lim + 1);
                    default: v = 32'(longint'($urandom_range(0, 32'(2 * lim))) - lim);
                endcase
                if ($urandom_range(0, 1) == 1)
                    v = -v;
            end
            7: begin
                case ($urandom_range(0, 4))
                    0:       v = 32'h7FFF_FFFF;
                    1:       v = 32'h8000_0000;
                    2:       v = 32'h0000_0000;
                    3:       v = 32'h0000_0001;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
            default: v = $urandom_range(0, 32'h20_0000) - 32'h10_0000;
        endcase
        return v;
    endfunction

    // Enabled runs of 1..30 ticks separated by 1..3 disabled ticks, with rare flips.
    function automatic bit next_enable();
        if (en_left == 0) begin
            en_state = !en_state;
            en_left  = en_state ? $urandom_range(1, 30) : $urandom_range(1, 3);
        end
        en_left--;
        if ($urandom_range(0, 19) == 0)
            return !en_state;
        return en_state;
    endfunction

    task automatic run_random(int n);
        repeat (n) send_sel(pick_error(sb.margin), next_enable());
    endtask

    function automatic logic [GAIN_W-1:0] small_gain();
        return 24'($urandom_range(0, 32'h4_0000)) - 24'h2_0000;
    endfunction

    initial begin
        sb         = new();
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        hold_req   = 1'b0;
        en_state   = 1'b0;
        en_left    = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: margin edges, error extremes, disable and idle ticks
        send_sel(32'd0, 1'b0);
        send_sel(32'h7FFF_FFFF, 1'b1);
        send_sel(32'h8000_0000, 1'b1);
        send_sel(32'd3276, 1'b1);
        send_sel(32'd3277, 1'b1);
        send_sel(-32'sd3276, 1'b1);
        send_sel(-32'sd3277, 1'b1);
        send_sel(32'd0, 1'b0);
        send_sel(32'd5000, 1'b0);
        send_sel(32'd1, 1'b1);
        send_sel(32'hFFFF_FFFF, 1'b1);
        send_sel(32'd0, 1'b0);
        run_random(135);

        // no margin: drive the integral into its upper limit
        configure(AXIS_LIN_Y, 31'd0, 24'h7F_FFFF, 24'h7F_FFFF, 24'h7F_FFFF);
        repeat (280) send_sel(32'h7FFF_FFFF, 1'b1);
        run_random(135);

        configure(AXIS_LIN_Z, 31'h7FFF_FFFF, 24'h80_0000, 24'h80_0000, 24'h80_0000);
        run_random(135);

        // clear with a zero error, then drive the integral into its lower limit
        configure(AXIS_ANG_X, 31'd1, small_gain(), 24'h80_0000, 24'h7F_FFFF);
        send_sel(32'd0, 1'b1);
        repeat (280) send_sel(32'h8000_0000, 1'b1);
        run_random(135);

        configure(AXIS_ANG_Y, 31'($urandom_range(0, 32'h4_0000)),
                  24'($urandom()), 24'($urandom()), 24'($urandom()));
        hold_req = 1'b1;
        run_random(135);

        configure(AXIS_ANG_Z, 31'($urandom()), small_gain(), small_gain(), small_gain());
        run_random(135);

        configure(AXIS_UNUSED_LO, 31'($urandom_range(0, 32'h1_0000)),
                  24'($urandom()), 24'($urandom()), 24'($urandom()));
        run_random(135);

        configure(AXIS_UNUSED_HI, 31'd0, small_gain(), small_gain(), small_gain());
        run_random(135);

        // last stretch at full rate on both sides
        configure(AXIS_W'($urandom_range(0, NUM_AXES - 1)),
                  31'($urandom_range(1000, 70000)), small_gain(), small_gain(), small_gain());
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        run_random(135);

        drain();
        repeat (8) @(posedge aclk);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[sim.f]
sv/apid_pkg.sv
sv/apid_regs.sv
sv/apid_core.sv
sv/axis_pid_with_margin.sv
dv/tb_top.sv
